[hw/rtl/tbs_pkg.sv]
// Shared constants, register codes and the tap control type for the
// texture bilinear sampler. No dependencies.
package tbs_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int SIZE_W    = 9;
  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int TEXEL_W   = 24;
  localparam int CHAN_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic MODE_POINT    = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam logic [CHAN_W-1:0] CHAN_MAX   = 16'hFF00;

  typedef struct packed {
    logic              smp;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } tap_ctl_t;

endpackage

[hw/rtl/tbs_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read.
// No dependencies.
module tbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/tbs_coord.sv]
// Coordinate scaling, edge clamping and texel address generation.
// Also carries write items down to the memory stage. Depends on tbs_pkg.
module tbs_coord #(
  parameter int MAX_WIDTH  = tbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       accept,
  input  logic                                       cmd,
  input  logic [tbs_pkg::INDEX_W-1:0]                texel_index,
  input  logic [tbs_pkg::TEXEL_W-1:0]                texel,
  input  logic [tbs_pkg::COORD_W-1:0]                coord_u,
  input  logic [tbs_pkg::COORD_W-1:0]                coord_v,
  input  logic                                       filter_mode,
  input  logic [tbs_pkg::SIZE_W-1:0]                 w,
  input  logic [tbs_pkg::SIZE_W-1:0]                 h,
  output logic                                       wr_en,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    wr_addr,
  output logic [tbs_pkg::TEXEL_W-1:0]                wr_data,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    addr00,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    addr10,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    addr01,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    addr11,
  output tbs_pkg::tap_ctl_t                          ctl
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = tbs_pkg::SIZE_W;
  localparam int FW     = tbs_pkg::FRAC_W;
  localparam int PROD_W = tbs_pkg::COORD_W + SW;
  localparam int ROW_W  = 2 * SW;

  // stage 1: scaled coordinates, write item
  logic              p1_smp;
  logic              p1_wr;
  logic [PROD_W-1:0] su;
  logic [PROD_W-1:0] sv;
  logic [AW-1:0]     p1_waddr;
  logic [tbs_pkg::TEXEL_W-1:0] p1_wdata;

  logic [PROD_W-1:0] su_next;
  logic [PROD_W-1:0] sv_next;
  logic              in_range;

  assign su_next  = {{SW{1'b0}}, coord_u} * {{tbs_pkg::COORD_W{1'b0}}, w};
  assign sv_next  = {{SW{1'b0}}, coord_v} * {{tbs_pkg::COORD_W{1'b0}}, h};
  assign in_range = 32'(texel_index) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_smp <= 1'b0;
      p1_wr  <= 1'b0;
    end else begin
      p1_smp <= accept && (cmd == tbs_pkg::CMD_SAMPLE);
      p1_wr  <= accept && (cmd == tbs_pkg::CMD_WRITE) && in_range;
    end
  end

  always_ff @(posedge clk) begin
    su       <= su_next;
    sv       <= sv_next;
    p1_waddr <= AW'(texel_index);
    p1_wdata <= texel;
  end

  // stage 2: clamp to the texture, row offsets
  logic [SW-1:0] x_raw, y_raw, w_m1, h_m1;
  logic [SW-1:0] x0, x1, y0, y1;
  logic [FW-1:0] fx, fy;
  logic [ROW_W-1:0] row0_next, row1_next;

  always_comb begin
    x_raw = su[PROD_W-1:tbs_pkg::COORD_W];
    y_raw = sv[PROD_W-1:tbs_pkg::COORD_W];
    w_m1  = w - SW'(1);
    h_m1  = h - SW'(1);
    x0    = (x_raw > w_m1) ? w_m1 : x_raw;
    y0    = (y_raw > h_m1) ? h_m1 : y_raw;
    // plus-one neighbors stick to the last column and row
    x1    = (x0 == w_m1) ? w_m1 : x0 + SW'(1);
    y1    = (y0 == h_m1) ? h_m1 : y0 + SW'(1);
    // point mode: all four taps fetch the base texel, zero weights
    if (filter_mode == tbs_pkg::MODE_BILINEAR) begin
      fx = su[tbs_pkg::COORD_W-1 -: FW];
      fy = sv[tbs_pkg::COORD_W-1 -: FW];
    end else begin
      fx = '0;
      fy = '0;
      x1 = x0;
      y1 = y0;
    end
    row0_next = {{SW{1'b0}}, y0} * {{SW{1'b0}}, w};
    row1_next = {{SW{1'b0}}, y1} * {{SW{1'b0}}, w};
  end

  logic              p2_smp;
  logic              p2_wr;
  logic [ROW_W-1:0]  p2_row0, p2_row1;
  logic [SW-1:0]     p2_x0, p2_x1;
  logic [FW-1:0]     p2_fx, p2_fy;
  logic [AW-1:0]     p2_waddr;
  logic [tbs_pkg::TEXEL_W-1:0] p2_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_smp <= 1'b0;
      p2_wr  <= 1'b0;
    end else begin
      p2_smp <= p1_smp;
      p2_wr  <= p1_wr;
    end
  end

  always_ff @(posedge clk) begin
    p2_row0  <= row0_next;
    p2_row1  <= row1_next;
    p2_x0    <= x0;
    p2_x1    <= x1;
    p2_fx    <= fx;
    p2_fy    <= fy;
    p2_waddr <= p1_waddr;
    p2_wdata <= p1_wdata;
  end

  // memory stage: writes land here too, so they stay in order with reads
  logic [ROW_W:0] sum00, sum10, sum01, sum11;

  assign sum00 = {1'b0, p2_row0} + (ROW_W+1)'(p2_x0);
  assign sum10 = {1'b0, p2_row0} + (ROW_W+1)'(p2_x1);
  assign sum01 = {1'b0, p2_row1} + (ROW_W+1)'(p2_x0);
  assign sum11 = {1'b0, p2_row1} + (ROW_W+1)'(p2_x1);

  assign addr00  = AW'(sum00);
  assign addr10  = AW'(sum10);
  assign addr01  = AW'(sum01);
  assign addr11  = AW'(sum11);
  assign wr_en   = p2_wr;
  assign wr_addr = p2_waddr;
  assign wr_data = p2_wdata;
  assign ctl     = '{smp: p2_smp, fx: p2_fx, fy: p2_fy};

endmodule

[hw/rtl/tbs_blend.sv]
// Two-pass bilinear blend of four fetched texels, three channels each.
// Registers the result and its strobe. Depends on tbs_pkg.
module tbs_blend (
  input  logic                         clk,
  input  logic                         rst,
  input  tbs_pkg::tap_ctl_t            ctl,
  input  logic [tbs_pkg::TEXEL_W-1:0]  t00,
  input  logic [tbs_pkg::TEXEL_W-1:0]  t10,
  input  logic [tbs_pkg::TEXEL_W-1:0]  t01,
  input  logic [tbs_pkg::TEXEL_W-1:0]  t11,
  output logic                         done,
  output logic [tbs_pkg::CHAN_W-1:0]   chan_first,
  output logic [tbs_pkg::CHAN_W-1:0]   chan_second,
  output logic [tbs_pkg::CHAN_W-1:0]   chan_third
);

  localparam int BW = tbs_pkg::BYTE_W;
  localparam int FW = tbs_pkg::FRAC_W;
  localparam int CW = tbs_pkg::CHAN_W;
  localparam int HW = CW + 1;
  localparam int VW = CW + FW + 1;

  // align control with the registered memory data
  tbs_pkg::tap_ctl_t q_ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctl.smp <= 1'b0;
    end else begin
      q_ctl.smp <= ctl.smp;
    end
    q_ctl.fx <= ctl.fx;
    q_ctl.fy <= ctl.fy;
  end

  // horizontal pass
  logic [HW-1:0] top_sum [3];
  logic [HW-1:0] bot_sum [3];
  logic [FW:0]   wx0;

  always_comb begin
    wx0 = (FW+1)'(1 << FW) - {1'b0, q_ctl.fx};
    for (int k = 0; k < 3; k++) begin
      top_sum[k] = HW'(t00[k*BW +: BW]) * HW'(wx0) + HW'(t10[k*BW +: BW]) * HW'(q_ctl.fx);
      bot_sum[k] = HW'(t01[k*BW +: BW]) * HW'(wx0) + HW'(t11[k*BW +: BW]) * HW'(q_ctl.fx);
    end
  end

  logic          r_smp;
  logic [FW-1:0] r_fy;
  logic [CW-1:0] top_q [3];
  logic [CW-1:0] bot_q [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_smp <= 1'b0;
    end else begin
      r_smp <= q_ctl.smp;
    end
  end

  always_ff @(posedge clk) begin
    r_fy <= q_ctl.fy;
    for (int k = 0; k < 3; k++) begin
      top_q[k] <= top_sum[k][CW-1:0];
      bot_q[k] <= bot_sum[k][CW-1:0];
    end
  end

  // vertical pass, truncate the low byte
  logic [VW-1:0] v_sum [3];
  logic [CW-1:0] res [3];
  logic [FW:0]   wy0;

  always_comb begin
    wy0 = (FW+1)'(1 << FW) - {1'b0, r_fy};
    for (int k = 0; k < 3; k++) begin
      v_sum[k] = VW'(top_q[k]) * VW'(wy0) + VW'(bot_q[k]) * VW'(r_fy);
      res[k]   = v_sum[k][CW+FW-1:FW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_smp;
    end
  end

  // channels leave in reversed order
  always_ff @(posedge clk) begin
    chan_first  <= res[2];
    chan_second <= res[1];
    chan_third  <= res[0];
  end

endmodule

[hw/rtl/texture_bilinear_sampler.sv]
// A sample's strobe runs p1_smp, p2_smp, q_ctl.smp, r_smp, then done.
// Throughput: one item per cycle; busy never rises, the pipeline has fixed latency.
// Two dual-read copies of the texel store give four fetches in the same memory cycle.
// Reset clears the pipeline and sets bilinear mode at 256 by 256 texels.
// The texel store has no clearing pass; its contents are undefined until written.
// Depends on tbs_pkg, tbs_ram, tbs_coord, tbs_blend.
module texture_bilinear_sampler #(
  parameter int MAX_WIDTH  = tbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd,
  input  logic [tbs_pkg::INDEX_W-1:0]     texel_index,
  input  logic [tbs_pkg::BYTE_W-1:0]      byte_zero,
  input  logic [tbs_pkg::BYTE_W-1:0]      byte_one,
  input  logic [tbs_pkg::BYTE_W-1:0]      byte_two,
  input  logic [tbs_pkg::COORD_W-1:0]     coord_u,
  input  logic [tbs_pkg::COORD_W-1:0]     coord_v,
  input  logic                            cfg_wr_en,
  input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbs_pkg::SIZE_W-1:0]      cfg_data,
  output logic                            done,
  output logic [tbs_pkg::CHAN_W-1:0]      chan_first,
  output logic [tbs_pkg::CHAN_W-1:0]      chan_second,
  output logic [tbs_pkg::CHAN_W-1:0]      chan_third
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = tbs_pkg::SIZE_W;
  localparam logic [SW-1:0] W_CAP = SW'((MAX_WIDTH  < 511) ? MAX_WIDTH  : 511);
  localparam logic [SW-1:0] H_CAP = SW'((MAX_HEIGHT < 511) ? MAX_HEIGHT : 511);

  logic          filter_mode;
  logic [SW-1:0] tex_width;
  logic [SW-1:0] tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= tbs_pkg::MODE_BILINEAR;
      tex_width   <= tbs_pkg::SIZE_RESET;
      tex_height  <= tbs_pkg::SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tbs_pkg::REG_FILTER_MODE: filter_mode <= cfg_data[0];
        tbs_pkg::REG_TEX_WIDTH:   tex_width   <= cfg_data;
        tbs_pkg::REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a size of zero acts as one, anything past the store limit as the limit
  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    if (tex_width == '0) begin
      w_eff = SW'(1);
    end else if (tex_width > W_CAP) begin
      w_eff = W_CAP;
    end else begin
      w_eff = tex_width;
    end
    if (tex_height == '0) begin
      h_eff = SW'(1);
    end else if (tex_height > H_CAP) begin
      h_eff = H_CAP;
    end else begin
      h_eff = tex_height;
    end
  end

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [tbs_pkg::TEXEL_W-1:0] wr_data;
  logic [AW-1:0]               addr00, addr10, addr01, addr11;
  tbs_pkg::tap_ctl_t           ctl;

  tbs_coord #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_coord (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .texel_index (texel_index),
    .texel       ({byte_two, byte_one, byte_zero}),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .filter_mode (filter_mode),
    .w           (w_eff),
    .h           (h_eff),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .addr00      (addr00),
    .addr10      (addr10),
    .addr01      (addr01),
    .addr11      (addr11),
    .ctl         (ctl)
  );

  logic [tbs_pkg::TEXEL_W-1:0] t00, t10, t01, t11;

  // upper row copy
  tbs_ram #(
    .WIDTH (tbs_pkg::TEXEL_W),
    .DEPTH (DEPTH)
  ) u_ram_row0 (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (addr00),
    .raddr_b (addr10),
    .rdata_a (t00),
    .rdata_b (t10)
  );

  // lower row copy
  tbs_ram #(
    .WIDTH (tbs_pkg::TEXEL_W),
    .DEPTH (DEPTH)
  ) u_ram_row1 (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .raddr_a (addr01),
    .raddr_b (addr11),
    .rdata_a (t01),
    .rdata_b (t11)
  );

  tbs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .t00         (t00),
    .t10         (t10),
    .t01         (t01),
    .t11         (t11),
    .done        (done),
    .chan_first  (chan_first),
    .chan_second (chan_second),
    .chan_third  (chan_third)
  );

`ifndef SYNTHESIS
  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == tbs_pkg::CMD_SAMPLE) |-> ##5 done)
    else $error("sample item produced no result");

  a_result_has_sample: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && cmd == tbs_pkg::CMD_SAMPLE, 5))
    else $error("result without a sample item");

  a_write_slot_alone: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !ctl.smp)
    else $error("write and sample in the memory stage together");

  a_right_neighbor: assert property (@(posedge clk) disable iff (rst)
    ctl.smp |-> (addr10 == addr00 || addr10 == addr00 + AW'(1)))
    else $error("right neighbor address off");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (chan_first <= tbs_pkg::CHAN_MAX && chan_second <= tbs_pkg::CHAN_MAX
              && chan_third <= tbs_pkg::CHAN_MAX))
    else $error("channel out of range");
`endif

endmodule
